@@ hdl/vnorm_pkg.sv @@
// vnorm_pkg: widths, stage counts and the sidecar types of the 2-d vector normalize unit
// no dependencies

package vnorm_pkg;

    localparam int COORD_BITS = 32;
    localparam int MAG_W      = 32;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQ_REM_W   = 36;
    localparam int LEN_W      = 31;
    localparam int QUO_W      = 17;
    localparam int DIR_W      = 18;
    localparam int DIV_REM_W  = 33;
    localparam int SQ_STAGES  = SUM_W / 2;

    typedef struct packed {
        logic             sx;
        logic             sz;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] az;
    } side_t;

    typedef struct packed {
        logic             sx;
        logic             sz;
        logic             zero;
        logic [LEN_W-1:0] len;
    } div_side_t;

endpackage

@@ hdl/vnorm_if.sv @@
// vnorm_in_if / vnorm_out_if: valid/ready channels of the vector normalize unit
// depends on vnorm_pkg

interface vnorm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_z;

    modport source (output valid, start_x, start_z, end_x, end_z, input ready);
    modport sink   (input valid, start_x, start_z, end_x, end_z, output ready);
endinterface

interface vnorm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [vnorm_pkg::LEN_W-1:0]           seg_length;
    logic signed [vnorm_pkg::DIR_W-1:0]    dir_x;
    logic signed [vnorm_pkg::DIR_W-1:0]    dir_z;

    modport source (output valid, seg_length, dir_x, dir_z, input ready);
    modport sink   (input valid, seg_length, dir_x, dir_z, output ready);
endinterface

@@ hdl/vnorm_sqrt.sv @@
// vnorm_sqrt: pipelined integer square root, two radicand bits per stage
// depends on vnorm_pkg

module vnorm_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [vnorm_pkg::SUM_W-1:0]   in_sum,
    input  vnorm_pkg::side_t              in_side,
    output logic                          out_valid,
    output logic [vnorm_pkg::ROOT_W-1:0]  out_root,
    output vnorm_pkg::side_t              out_side
);

    localparam int N = vnorm_pkg::SQ_STAGES;

    logic                              valid_reg [0:N];
    logic [vnorm_pkg::SQ_REM_W-1:0]    rem_reg   [0:N];
    logic [vnorm_pkg::ROOT_W-1:0]      root_reg  [0:N];
    logic [vnorm_pkg::SUM_W-1:0]       rad_reg   [0:N];
    vnorm_pkg::side_t                  side_reg  [0:N];

    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = '0;
        root_reg[0]  = '0;
        rad_reg[0]   = in_sum;
        side_reg[0]  = in_side;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [vnorm_pkg::SQ_REM_W-1:0] shifted;
        logic [vnorm_pkg::SQ_REM_W-1:0] trial;
        logic                           fits;

        always_comb
        begin
            shifted = {rem_reg[k][vnorm_pkg::SQ_REM_W-3:0],
                       rad_reg[k][vnorm_pkg::SUM_W-1 -: 2]};
            trial   = {{(vnorm_pkg::SQ_REM_W-vnorm_pkg::ROOT_W-2){1'b0}}, root_reg[k], 2'b01};
            fits    = (shifted >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= fits ? (shifted - trial) : shifted;
                root_reg[k+1] <= {root_reg[k][vnorm_pkg::ROOT_W-2:0], fits};
                rad_reg[k+1]  <= {rad_reg[k][vnorm_pkg::SUM_W-3:0], 2'b00};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

@@ hdl/vnorm_div.sv @@
// vnorm_div: two-lane pipelined restoring divider, (mag << 16) / len, one quotient bit per stage
// depends on vnorm_pkg

module vnorm_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [vnorm_pkg::MAG_W-1:0]   in_ax,
    input  logic [vnorm_pkg::MAG_W-1:0]   in_az,
    input  vnorm_pkg::div_side_t          in_side,
    output logic                          out_valid,
    output logic [vnorm_pkg::QUO_W-1:0]   out_qx,
    output logic [vnorm_pkg::QUO_W-1:0]   out_qz,
    output vnorm_pkg::div_side_t          out_side
);

    localparam int N = vnorm_pkg::QUO_W;
    localparam int RW = vnorm_pkg::DIV_REM_W;

    logic                         valid_reg [0:N];
    logic [RW-1:0]                rx_reg    [0:N];
    logic [RW-1:0]                rz_reg    [0:N];
    logic [N-1:0]                 qx_reg    [0:N];
    logic [N-1:0]                 qz_reg    [0:N];
    vnorm_pkg::div_side_t         side_reg  [0:N];

    always_comb
    begin
        valid_reg[0] = in_valid;
        rx_reg[0]    = {{(RW-vnorm_pkg::MAG_W){1'b0}}, in_ax};
        rz_reg[0]    = {{(RW-vnorm_pkg::MAG_W){1'b0}}, in_az};
        qx_reg[0]    = '0;
        qz_reg[0]    = '0;
        side_reg[0]  = in_side;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [RW-1:0] divisor;
        logic [RW-1:0] px;
        logic [RW-1:0] pz;
        logic          fx;
        logic          fz;

        always_comb
        begin
            divisor = {{(RW-vnorm_pkg::LEN_W){1'b0}}, side_reg[k].len};
            // first stage takes the integer part, later ones bring in a zero bit
            px = (k == 0) ? rx_reg[k] : {rx_reg[k][RW-2:0], 1'b0};
            pz = (k == 0) ? rz_reg[k] : {rz_reg[k][RW-2:0], 1'b0};
            fx = (px >= divisor);
            fz = (pz >= divisor);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[k+1]   <= fx ? (px - divisor) : px;
                rz_reg[k+1]   <= fz ? (pz - divisor) : pz;
                qx_reg[k+1]   <= {qx_reg[k][N-2:0], fx};
                qz_reg[k+1]   <= {qz_reg[k][N-2:0], fz};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_qx    = qx_reg[N];
    assign out_qz    = qz_reg[N];
    assign out_side  = side_reg[N];

endmodule

@@ hdl/vector_normalize_2d_fixed_unit.sv @@
// vector_normalize_2d_fixed_unit: segment length and unit direction, 16.16 fixed point
// depends on vnorm_pkg, vnorm_if, vnorm_sqrt, vnorm_div
//
//   channel   role    payload
//   seg_in    sink    start_x, start_z, end_x, end_z (signed 16.16)
//   seg_out   source  seg_length (15.16, floor, saturated), dir_x, dir_z (signed 2.16)
//
// one item per cycle sustained while seg_out is not stalled; stages: 3 front stages (difference,
// squares, sum), 32 root stages, 1 clamp stage, 17 divider stages, 1 output register
// the whole pipeline moves as one when the output register is empty or taken
// a stall freezes every stage, valid bits ride along with the data
// reset clears only the valid bits

module vector_normalize_2d_fixed_unit
(
    input  logic         clk,
    input  logic         rst_n,
    vnorm_in_if.sink     seg_in,
    vnorm_out_if.source  seg_out
);

    localparam int CB = vnorm_pkg::COORD_BITS;

    // global advance: the output register is free or being emptied
    logic adv;
    assign adv          = !seg_out.valid || seg_out.ready;
    assign seg_in.ready = adv;

    // stage 1: wrapped differences as sign and magnitude
    logic [CB-1:0]                 dx_w;
    logic [CB-1:0]                 dz_w;
    logic [CB-1:0]                 mx_w;
    logic [CB-1:0]                 mz_w;
    logic                          s1_valid_reg;
    vnorm_pkg::side_t              s1_side_reg;

    always_comb
    begin
        dx_w = seg_in.end_x[CB-1:0] - seg_in.start_x[CB-1:0];
        dz_w = seg_in.end_z[CB-1:0] - seg_in.start_z[CB-1:0];
        mx_w = dx_w[CB-1] ? (~dx_w + 1'b1) : dx_w;
        mz_w = dz_w[CB-1] ? (~dz_w + 1'b1) : dz_w;
    end

    // stage 2: squares, stage 3: sum
    logic                          s2_valid_reg;
    vnorm_pkg::side_t              s2_side_reg;
    logic [2*vnorm_pkg::MAG_W-1:0] sqx_reg;
    logic [2*vnorm_pkg::MAG_W-1:0] sqz_reg;
    logic                          s3_valid_reg;
    vnorm_pkg::side_t              s3_side_reg;
    logic [vnorm_pkg::SUM_W-1:0]   sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= seg_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg.sx <= dx_w[CB-1];
            s1_side_reg.sz <= dz_w[CB-1];
            s1_side_reg.ax <= vnorm_pkg::MAG_W'(mx_w);
            s1_side_reg.az <= vnorm_pkg::MAG_W'(mz_w);
            s2_side_reg    <= s1_side_reg;
            sqx_reg        <= s1_side_reg.ax * s1_side_reg.ax;
            sqz_reg        <= s1_side_reg.az * s1_side_reg.az;
            s3_side_reg    <= s2_side_reg;
            sum_reg        <= vnorm_pkg::SUM_W'(sqx_reg) + vnorm_pkg::SUM_W'(sqz_reg);
        end
    end

    // square root pipeline
    logic                          rt_valid;
    logic [vnorm_pkg::ROOT_W-1:0]  rt_root;
    vnorm_pkg::side_t              rt_side;

    vnorm_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .in_sum    (sum_reg),
        .in_side   (s3_side_reg),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    // clamp stage: saturate the length, flag zero length
    logic                          cl_valid_reg;
    vnorm_pkg::div_side_t          cl_side_reg;
    logic [vnorm_pkg::MAG_W-1:0]   cl_ax_reg;
    logic [vnorm_pkg::MAG_W-1:0]   cl_az_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cl_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl_side_reg.sx   <= rt_side.sx;
            cl_side_reg.sz   <= rt_side.sz;
            cl_side_reg.zero <= (rt_root == '0);
            cl_side_reg.len  <= rt_root[vnorm_pkg::ROOT_W-1] ? {vnorm_pkg::LEN_W{1'b1}}
                                                             : rt_root[vnorm_pkg::LEN_W-1:0];
            cl_ax_reg        <= rt_side.ax;
            cl_az_reg        <= rt_side.az;
        end
    end

    // divider pipeline, both components side by side
    logic                          dv_valid;
    logic [vnorm_pkg::QUO_W-1:0]   dv_qx;
    logic [vnorm_pkg::QUO_W-1:0]   dv_qz;
    vnorm_pkg::div_side_t          dv_side;

    vnorm_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cl_valid_reg),
        .in_ax     (cl_ax_reg),
        .in_az     (cl_az_reg),
        .in_side   (cl_side_reg),
        .out_valid (dv_valid),
        .out_qx    (dv_qx),
        .out_qz    (dv_qz),
        .out_side  (dv_side)
    );

    // output register: restore signs, zero vector on zero length
    logic                                out_valid_reg;
    logic [vnorm_pkg::LEN_W-1:0]         len_reg;
    logic [vnorm_pkg::DIR_W-1:0]         dir_x_reg;
    logic [vnorm_pkg::DIR_W-1:0]         dir_z_reg;
    logic [vnorm_pkg::DIR_W-1:0]         ux;
    logic [vnorm_pkg::DIR_W-1:0]         uz;

    always_comb
    begin
        ux = {1'b0, dv_qx};
        uz = {1'b0, dv_qz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg   <= dv_side.len;
            dir_x_reg <= dv_side.zero ? '0 : (dv_side.sx ? (~ux + 1'b1) : ux);
            dir_z_reg <= dv_side.zero ? '0 : (dv_side.sz ? (~uz + 1'b1) : uz);
        end
    end

    assign seg_out.valid      = out_valid_reg;
    assign seg_out.seg_length = len_reg;
    assign seg_out.dir_x      = dir_x_reg;
    assign seg_out.dir_z      = dir_z_reg;

endmodule

@@ hdl/vnorm_checker.sv @@
// vnorm_checker: port-level assertions for the vector normalize unit, bound to the top level
// depends on vnorm_pkg and vector_normalize_2d_fixed_unit

module vnorm_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [vnorm_pkg::LEN_W-1:0]         seg_length,
    input logic signed [vnorm_pkg::DIR_W-1:0]  dir_x,
    input logic signed [vnorm_pkg::DIR_W-1:0]  dir_z
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seg_length) && $stable(dir_x)
                                    && $stable(dir_z))
        else $error("result changed while stalled");

    // input side is open whenever the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input not ready with free output");

    // zero length gives a zero vector
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seg_length == '0 |-> dir_x == '0 && dir_z == '0)
        else $error("nonzero direction on zero length");

    // direction components stay within one unit
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dir_x <= 18'sd65536 && dir_x >= -18'sd65536
                   && dir_z <= 18'sd65536 && dir_z >= -18'sd65536)
        else $error("direction out of range");

endmodule

bind vector_normalize_2d_fixed_unit vnorm_checker u_vnorm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (seg_in.ready),
    .out_valid  (seg_out.valid),
    .out_ready  (seg_out.ready),
    .seg_length (seg_out.seg_length),
    .dir_x      (seg_out.dir_x),
    .dir_z      (seg_out.dir_z)
);
